[sv/rcl_pkg.sv]
// rcl_pkg: shared types and constants for the recent contact list
// used by rcl_ctrl, rcl_datapath and recent_contact_list_top
package rcl_pkg;

  localparam int RCL_ENTRIES = 16;
  localparam int ID_W        = 32;
  localparam int CODE_W      = 8;
  localparam int PROF_W      = 32;
  localparam int INDEX_W     = 6;
  localparam int COUNT_W     = 7;
  localparam int EXCH_W      = 17;
  localparam logic [EXCH_W-1:0] EXCH_MAX = 17'd99999;

  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_READ   = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_COUNT  = 2'd3
  } rcl_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_OUT
  } rcl_state_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } rcl_cmd_t;

endpackage

[sv/rcl_ctrl.sv]
// rcl_ctrl: sequencing state machine for the recent contact list
// depends on rcl_pkg; drives rcl_datapath through rcl_cmd_t
module rcl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output rcl_pkg::rcl_cmd_t cmd
);
  import rcl_pkg::*;

  rcl_state_t state_r;
  rcl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    busy        = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        busy        = 1'b1;
        cmd.compare = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        busy       = 1'b1;
        cmd.update = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[sv/rcl_datapath.sv]
// rcl_datapath: entry shift chain, per-entry id comparators, counter, result regs
// depends on rcl_pkg; commanded by rcl_ctrl
module rcl_datapath #(
  parameter int ENTRIES = rcl_pkg::RCL_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rcl_pkg::rcl_cmd_t            cmd,
  input  logic [1:0]                   in_mode,
  input  logic [rcl_pkg::ID_W-1:0]     in_player_id,
  input  logic [rcl_pkg::CODE_W-1:0]   in_origin_code,
  input  logic [rcl_pkg::CODE_W-1:0]   in_view_code,
  input  logic [rcl_pkg::PROF_W-1:0]   in_profile_bits,
  input  logic [rcl_pkg::INDEX_W-1:0]  in_entry_index,
  output logic                         out_hit,
  output logic [rcl_pkg::INDEX_W-1:0]  out_hit_index,
  output logic [rcl_pkg::ID_W-1:0]     out_read_id,
  output logic [rcl_pkg::CODE_W-1:0]   out_read_origin,
  output logic [rcl_pkg::CODE_W-1:0]   out_read_view,
  output logic [rcl_pkg::PROF_W-1:0]   out_read_profile,
  output logic                         out_entry_present,
  output logic [rcl_pkg::COUNT_W-1:0]  out_valid_count,
  output logic [rcl_pkg::EXCH_W-1:0]   out_exchange_count
);
  import rcl_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [ID_W-1:0]    ids_r      [ENTRIES];
  logic [CODE_W-1:0]  origins_r  [ENTRIES];
  logic [CODE_W-1:0]  views_r    [ENTRIES];
  logic [PROF_W-1:0]  profiles_r [ENTRIES];
  logic [EXCH_W-1:0]  exch_r;

  rcl_mode_t          mode_r;
  logic [ID_W-1:0]    pid_r;
  logic [CODE_W-1:0]  org_r;
  logic [CODE_W-1:0]  view_r;
  logic [PROF_W-1:0]  prof_r;
  logic [INDEX_W-1:0] idx_r;

  logic [ENTRIES-1:0] match_r;
  logic [ID_W-1:0]    rd_id_r;
  logic [CODE_W-1:0]  rd_org_r;
  logic [CODE_W-1:0]  rd_view_r;
  logic [PROF_W-1:0]  rd_prof_r;
  logic               rd_present_r;

  logic               res_hit_r;
  logic [INDEX_W-1:0] res_idx_r;
  logic [ID_W-1:0]    res_id_r;
  logic [CODE_W-1:0]  res_org_r;
  logic [CODE_W-1:0]  res_view_r;
  logic [PROF_W-1:0]  res_prof_r;
  logic               res_present_r;

  logic               in_range;
  logic [IDX_W-1:0]   rd_addr;
  logic               any_hit;
  logic [IDX_W-1:0]   hit_pos;
  logic [CNT_W-1:0]   lead_cnt;
  logic               do_record;
  logic               hit_mode;

  // input word latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= rcl_mode_t'(in_mode);
      pid_r  <= in_player_id;
      org_r  <= in_origin_code;
      view_r <= in_view_code;
      prof_r <= in_profile_bits;
      idx_r  <= in_entry_index;
    end
  end

  assign in_range = {1'b0, idx_r} < COUNT_W'(ENTRIES);
  assign rd_addr  = in_range ? idx_r[IDX_W-1:0] : '0;

  // per-entry comparators and read port
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_r[i] <= (origins_r[i] != '0) && (ids_r[i] == pid_r);
      end
      rd_id_r      <= ids_r[rd_addr];
      rd_org_r     <= origins_r[rd_addr];
      rd_view_r    <= views_r[rd_addr];
      rd_prof_r    <= profiles_r[rd_addr];
      rd_present_r <= in_range && (ids_r[rd_addr] != '0);
    end
  end

  // first matching entry
  always_comb begin
    hit_pos = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_pos = IDX_W'(i);
      end
    end
  end
  assign any_hit   = |match_r;
  assign do_record = (mode_r == MODE_RECORD) && (pid_r != '0);
  assign hit_mode  = do_record || (mode_r == MODE_LOOKUP);

  // entry storage: dedup view update or shift-in at the front; exchange counter increment
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        ids_r[i]      <= '0;
        origins_r[i]  <= '0;
        views_r[i]    <= '0;
        profiles_r[i] <= '0;
      end
      exch_r <= '0;
    end else if (cmd.update) begin
      if (do_record) begin
        if (any_hit) begin
          views_r[hit_pos] <= view_r;
        end else begin
          for (int i = ENTRIES - 1; i > 0; i--) begin
            ids_r[i]      <= ids_r[i-1];
            origins_r[i]  <= origins_r[i-1];
            views_r[i]    <= views_r[i-1];
            profiles_r[i] <= profiles_r[i-1];
          end
          ids_r[0]      <= pid_r;
          origins_r[0]  <= org_r;
          views_r[0]    <= view_r;
          profiles_r[0] <= prof_r;
        end
      end
      if ((mode_r == MODE_COUNT) && (exch_r < EXCH_MAX)) begin
        exch_r <= exch_r + EXCH_W'(1);
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_hit_r <= hit_mode && any_hit;
      res_idx_r <= (hit_mode && any_hit) ? INDEX_W'(hit_pos) : '0;
      if (mode_r == MODE_READ) begin
        res_id_r      <= rd_id_r;
        res_org_r     <= rd_org_r;
        res_view_r    <= rd_view_r;
        res_prof_r    <= rd_prof_r;
        res_present_r <= rd_present_r;
      end else begin
        res_id_r      <= '0;
        res_org_r     <= '0;
        res_view_r    <= '0;
        res_prof_r    <= '0;
        res_present_r <= 1'b0;
      end
    end
  end

  // leading non-empty entries
  always_comb begin
    lead_cnt = CNT_W'(ENTRIES);
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (origins_r[i] == '0) begin
        lead_cnt = CNT_W'(i);
      end
    end
  end

  assign out_hit            = res_hit_r;
  assign out_hit_index      = res_idx_r;
  assign out_read_id        = res_id_r;
  assign out_read_origin    = res_org_r;
  assign out_read_view      = res_view_r;
  assign out_read_profile   = res_prof_r;
  assign out_entry_present  = res_present_r;
  assign out_valid_count    = COUNT_W'(lead_cnt);
  assign out_exchange_count = exch_r;

endmodule

[sv/recent_contact_list_top.sv]
// recent_contact_list_top: most recent first contact list with id dedup
// an accepted word is loaded, then runs the compare and update steps before the result strobe
// no new word is taken during the compare and update steps, while busy is high
// a new word is taken in the result cycle; results cannot be held off
// reset (rst_n low, synchronous) empties all entries and zeroes the counter
// depends on rcl_pkg, rcl_ctrl, rcl_datapath
module recent_contact_list_top #(
  parameter int ENTRIES = rcl_pkg::RCL_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic [rcl_pkg::ID_W-1:0]     in_player_id,
  input  logic [rcl_pkg::CODE_W-1:0]   in_origin_code,
  input  logic [rcl_pkg::CODE_W-1:0]   in_view_code,
  input  logic [rcl_pkg::PROF_W-1:0]   in_profile_bits,
  input  logic [rcl_pkg::INDEX_W-1:0]  in_entry_index,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [rcl_pkg::INDEX_W-1:0]  out_hit_index,
  output logic [rcl_pkg::ID_W-1:0]     out_read_id,
  output logic [rcl_pkg::CODE_W-1:0]   out_read_origin,
  output logic [rcl_pkg::CODE_W-1:0]   out_read_view,
  output logic [rcl_pkg::PROF_W-1:0]   out_read_profile,
  output logic                         out_entry_present,
  output logic [rcl_pkg::COUNT_W-1:0]  out_valid_count,
  output logic [rcl_pkg::EXCH_W-1:0]   out_exchange_count
);
  import rcl_pkg::*;

  rcl_cmd_t cmd;

  rcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rcl_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_mode            (in_mode),
    .in_player_id       (in_player_id),
    .in_origin_code     (in_origin_code),
    .in_view_code       (in_view_code),
    .in_profile_bits    (in_profile_bits),
    .in_entry_index     (in_entry_index),
    .out_hit            (out_hit),
    .out_hit_index      (out_hit_index),
    .out_read_id        (out_read_id),
    .out_read_origin    (out_read_origin),
    .out_read_view      (out_read_view),
    .out_read_profile   (out_read_profile),
    .out_entry_present  (out_entry_present),
    .out_valid_count    (out_valid_count),
    .out_exchange_count (out_exchange_count)
  );

  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted word produced no result strobe");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_exchange_count <= EXCH_MAX)
    else $error("exchange counter past its limit");

endmodule

[tb/contact_list_checker.sv]
// contact_list_checker: predicts every reply word of recent_contact_list_top and
// compares it field by field with what the block puts out
// depends on rcl_pkg; instantiated beside the block by recent_contact_list_top_tb
module contact_list_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic [rcl_pkg::ID_W-1:0]     in_player_id,
  input  logic [rcl_pkg::CODE_W-1:0]   in_origin_code,
  input  logic [rcl_pkg::CODE_W-1:0]   in_view_code,
  input  logic [rcl_pkg::PROF_W-1:0]   in_profile_bits,
  input  logic [rcl_pkg::INDEX_W-1:0]  in_entry_index,
  input  logic                         out_valid,
  input  logic                         out_hit,
  input  logic [rcl_pkg::INDEX_W-1:0]  out_hit_index,
  input  logic [rcl_pkg::ID_W-1:0]     out_read_id,
  input  logic [rcl_pkg::CODE_W-1:0]   out_read_origin,
  input  logic [rcl_pkg::CODE_W-1:0]   out_read_view,
  input  logic [rcl_pkg::PROF_W-1:0]   out_read_profile,
  input  logic                         out_entry_present,
  input  logic [rcl_pkg::COUNT_W-1:0]  out_valid_count,
  input  logic [rcl_pkg::EXCH_W-1:0]   out_exchange_count,
  output int                           fail_count,
  output int                           replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcl_pkg::*;

  typedef struct {
    logic               hit;
    logic [INDEX_W-1:0] hit_index;
    logic [ID_W-1:0]    read_id;
    logic [CODE_W-1:0]  read_origin;
    logic [CODE_W-1:0]  read_view;
    logic [PROF_W-1:0]  read_profile;
    logic               entry_present;
    logic [COUNT_W-1:0] valid_count;
    logic [EXCH_W-1:0]  exchange_count;
  } contact_reply_t;

  contact_reply_t    replies_due[$];
  logic [ID_W-1:0]   contact_id     [RCL_ENTRIES];
  logic [CODE_W-1:0] contact_origin [RCL_ENTRIES];
  logic [CODE_W-1:0] contact_view   [RCL_ENTRIES];
  logic [PROF_W-1:0] contact_profile[RCL_ENTRIES];
  logic [EXCH_W-1:0] exchange_tally;

  function automatic int find_contact(logic [ID_W-1:0] pid);
    for (int k = 0; k < RCL_ENTRIES; k++) begin
      if (contact_origin[k] != '0 && contact_id[k] == pid) return k;
    end
    return -1;
  endfunction

  function automatic contact_reply_t apply_contact_word(
      rcl_mode_t mode, logic [ID_W-1:0] pid, logic [CODE_W-1:0] org,
      logic [CODE_W-1:0] view, logic [PROF_W-1:0] prof, logic [INDEX_W-1:0] idx);
    contact_reply_t r;
    int pos;
    int n;
    int slot;
    r = '{default: '0};
    case (mode)
      MODE_RECORD: begin
        if (pid != '0) begin
          pos = find_contact(pid);
          if (pos >= 0) begin
            contact_view[pos] = view;
            r.hit = 1'b1;
            r.hit_index = INDEX_W'(pos);
          end else begin
            for (int k = RCL_ENTRIES - 1; k > 0; k--) begin
              contact_id[k]      = contact_id[k-1];
              contact_origin[k]  = contact_origin[k-1];
              contact_view[k]    = contact_view[k-1];
              contact_profile[k] = contact_profile[k-1];
            end
            contact_id[0]      = pid;
            contact_origin[0]  = org;
            contact_view[0]    = view;
            contact_profile[0] = prof;
          end
        end
      end
      MODE_READ: begin
        slot = (int'(idx) < RCL_ENTRIES) ? int'(idx) : 0;
        r.read_id       = contact_id[slot];
        r.read_origin   = contact_origin[slot];
        r.read_view     = contact_view[slot];
        r.read_profile  = contact_profile[slot];
        r.entry_present = (int'(idx) < RCL_ENTRIES) && (contact_id[slot] != '0);
      end
      MODE_LOOKUP: begin
        pos = find_contact(pid);
        if (pos >= 0) begin
          r.hit = 1'b1;
          r.hit_index = INDEX_W'(pos);
        end
      end
      default: begin
        if (exchange_tally < EXCH_MAX) exchange_tally = exchange_tally + 1'b1;
      end
    endcase
    n = 0;
    while (n < RCL_ENTRIES && contact_origin[n] != '0) n++;
    r.valid_count = COUNT_W'(n);
    r.exchange_count = exchange_tally;
    return r;
  endfunction

  task automatic report_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("reply mismatch on %s at %0t: got %0h, expected %0h", field, $time, got, want);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    contact_reply_t want;
    if (!rst_n) begin
      for (int k = 0; k < RCL_ENTRIES; k++) begin
        contact_id[k]      = '0;
        contact_origin[k]  = '0;
        contact_view[k]    = '0;
        contact_profile[k] = '0;
      end
      exchange_tally = '0;
      replies_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          $display("unexpected reply word at %0t", $time);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          report_field("hit", 32'(out_hit), 32'(want.hit));
          report_field("hit_index", 32'(out_hit_index), 32'(want.hit_index));
          report_field("read_id", out_read_id, want.read_id);
          report_field("read_origin", 32'(out_read_origin), 32'(want.read_origin));
          report_field("read_view", 32'(out_read_view), 32'(want.read_view));
          report_field("read_profile", out_read_profile, want.read_profile);
          report_field("entry_present", 32'(out_entry_present), 32'(want.entry_present));
          report_field("valid_count", 32'(out_valid_count), 32'(want.valid_count));
          report_field("exchange_count", 32'(out_exchange_count),
                       32'(want.exchange_count));
        end
      end
      if (start && !busy) begin
        replies_due.push_back(apply_contact_word(rcl_mode_t'(in_mode), in_player_id,
            in_origin_code, in_view_code, in_profile_bits, in_entry_index));
      end
    end
    replies_owed = replies_due.size();
  end

endmodule

[tb/recent_contact_list_top_tb.sv]
// recent_contact_list_top_tb: drives directed and random words
// into recent_contact_list_top and gives the verdict
// depends on rcl_pkg, recent_contact_list_top and contact_list_checker
module recent_contact_list_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcl_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_mode;
  logic [ID_W-1:0]     in_player_id;
  logic [CODE_W-1:0]   in_origin_code;
  logic [CODE_W-1:0]   in_view_code;
  logic [PROF_W-1:0]   in_profile_bits;
  logic [INDEX_W-1:0]  in_entry_index;
  logic                out_valid;
  logic                out_hit;
  logic [INDEX_W-1:0]  out_hit_index;
  logic [ID_W-1:0]     out_read_id;
  logic [CODE_W-1:0]   out_read_origin;
  logic [CODE_W-1:0]   out_read_view;
  logic [PROF_W-1:0]   out_read_profile;
  logic                out_entry_present;
  logic [COUNT_W-1:0]  out_valid_count;
  logic [EXCH_W-1:0]   out_exchange_count;

  int              fail_count;
  int              replies_owed;
  int              calm_left;
  logic [ID_W-1:0] id_pool[24];

  recent_contact_list_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_player_id       (in_player_id),
    .in_origin_code     (in_origin_code),
    .in_view_code       (in_view_code),
    .in_profile_bits    (in_profile_bits),
    .in_entry_index     (in_entry_index),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_hit_index      (out_hit_index),
    .out_read_id        (out_read_id),
    .out_read_origin    (out_read_origin),
    .out_read_view      (out_read_view),
    .out_read_profile   (out_read_profile),
    .out_entry_present  (out_entry_present),
    .out_valid_count    (out_valid_count),
    .out_exchange_count (out_exchange_count)
  );

  contact_list_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_player_id       (in_player_id),
    .in_origin_code     (in_origin_code),
    .in_view_code       (in_view_code),
    .in_profile_bits    (in_profile_bits),
    .in_entry_index     (in_entry_index),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_hit_index      (out_hit_index),
    .out_read_id        (out_read_id),
    .out_read_origin    (out_read_origin),
    .out_read_view      (out_read_view),
    .out_read_profile   (out_read_profile),
    .out_entry_present  (out_entry_present),
    .out_valid_count    (out_valid_count),
    .out_exchange_count (out_exchange_count),
    .fail_count         (fail_count),
    .replies_owed       (replies_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = int'($urandom_range(10, 30));
    return int'($urandom_range(0, 9));
  endfunction

  task automatic issue(rcl_mode_t mode, logic [ID_W-1:0] pid, logic [CODE_W-1:0] org,
                       logic [CODE_W-1:0] view, logic [PROF_W-1:0] prof,
                       logic [INDEX_W-1:0] idx, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_player_id    <= pid;
    in_origin_code  <= org;
    in_view_code    <= view;
    in_profile_bits <= prof;
    in_entry_index  <= idx;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int              pick;
    rcl_mode_t       mode;
    logic [ID_W-1:0] pid;
    logic [CODE_W-1:0] org;
    logic [INDEX_W-1:0] idx;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = MODE_RECORD;
    in_player_id    = '0;
    in_origin_code  = '0;
    in_view_code    = '0;
    in_profile_bits = '0;
    in_entry_index  = '0;
    calm_left       = 0;
    for (int k = 0; k < 24; k++) begin
      id_pool[k] = $urandom;
      if (id_pool[k] == '0) id_pool[k] = ID_W'(k + 1);
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, ignored id zero, then a full list
    issue(MODE_READ, '0, '0, '0, '0, '0, pick_gap());
    issue(MODE_LOOKUP, '0, '0, '0, '0, '0, pick_gap());
    issue(MODE_RECORD, '0, '1, '1, '1, '1, pick_gap());
    issue(MODE_RECORD, '1, '1, '1, '1, '1, pick_gap());
    issue(MODE_RECORD, ID_W'(1), CODE_W'(1), '0, '0, '0, pick_gap());
    for (int k = 2; k < RCL_ENTRIES; k++) begin
      issue(MODE_RECORD, ID_W'(k), CODE_W'($urandom_range(1, 255)), CODE_W'($urandom),
            $urandom, INDEX_W'($urandom), pick_gap());
    end
    // duplicate id, far end of the list, out of range read, empty insert
    issue(MODE_RECORD, ID_W'(1), CODE_W'(7), CODE_W'(8'hA5), '1, '0, pick_gap());
    issue(MODE_LOOKUP, '1, '0, '0, '0, '0, pick_gap());
    issue(MODE_READ, '0, '0, '0, '0, INDEX_W'(RCL_ENTRIES - 1), pick_gap());
    issue(MODE_READ, '0, '0, '0, '0, '1, pick_gap());
    issue(MODE_RECORD, ID_W'(32'h8000_0000), '0, '1, '1, '0, pick_gap());
    issue(MODE_COUNT, '1, '1, '1, '1, '1, pick_gap());

    for (int n = 0; n < 1125; n++) begin
      pick = int'($urandom_range(0, 99));
      mode = pick < 35 ? MODE_RECORD : pick < 60 ? MODE_READ :
             pick < 85 ? MODE_LOOKUP : MODE_COUNT;
      pick = int'($urandom_range(0, 99));
      pid = pick < 5 ? '0 : pick < 15 ? $urandom : id_pool[$urandom_range(0, 23)];
      org = ($urandom_range(0, 7) == 0) ? '0 : CODE_W'($urandom_range(1, 255));
      pick = int'($urandom_range(0, 99));
      idx = pick < 75 ? INDEX_W'($urandom_range(0, RCL_ENTRIES - 1)) :
            pick < 85 ? INDEX_W'($urandom_range(RCL_ENTRIES, 63)) : INDEX_W'($urandom);
      issue(mode, pid, org, CODE_W'($urandom), $urandom, idx, pick_gap());
    end

    issue(MODE_LOOKUP, id_pool[0], '0, '0, '0, '0, pick_gap());
    issue(MODE_READ, '0, '0, '0, '0, '0, pick_gap());

    start <= 1'b0;
    @(posedge clk);
    wait (replies_owed == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && replies_owed == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
sv/rcl_pkg.sv
sv/rcl_ctrl.sv
sv/rcl_datapath.sv
sv/recent_contact_list_top.sv
tb/contact_list_checker.sv
tb/recent_contact_list_top_tb.sv
